>>> hw/rtl/tiny_mlp_sigmoid_lut_inference_core_assert.svh
// Assertion macros used by the checker file of the inference core.
// Self-contained: no other file is needed.
`ifndef TINY_MLP_SIGMOID_LUT_INFERENCE_CORE_ASSERT_SVH
`define TINY_MLP_SIGMOID_LUT_INFERENCE_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while dis is high.
`define TMLP_ASSERT_SAME(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, clocked on clk, off while dis is high.
`define TMLP_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

>>> hw/rtl/tmlp_pkg.sv
// Types, register indexes, sigmoid table and rounding helper of the inference core.
// No dependencies; compiled before every other file.
`default_nettype none

package tmlp_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_sum;
    typedef logic [1:0]  t_cfg_idx;

    localparam int unsigned NUM_FEATURES = 7;

    localparam t_cfg_idx CFG_HIDDEN_A = 2'd0;
    localparam t_cfg_idx CFG_HIDDEN_B = 2'd1;
    localparam t_cfg_idx CFG_OUTPUT   = 2'd2;

    localparam t_byte SIGMOID_LUT [256] = '{
        8'd12,  8'd12,  8'd12,  8'd12,  8'd13,  8'd13,  8'd13,  8'd14,
        8'd14,  8'd14,  8'd15,  8'd15,  8'd15,  8'd16,  8'd16,  8'd16,
        8'd17,  8'd17,  8'd18,  8'd18,  8'd18,  8'd19,  8'd19,  8'd20,
        8'd20,  8'd21,  8'd21,  8'd21,  8'd22,  8'd22,  8'd23,  8'd23,
        8'd24,  8'd24,  8'd25,  8'd26,  8'd26,  8'd27,  8'd27,  8'd28,
        8'd28,  8'd29,  8'd30,  8'd30,  8'd31,  8'd32,  8'd32,  8'd33,
        8'd34,  8'd34,  8'd35,  8'd36,  8'd36,  8'd37,  8'd38,  8'd39,
        8'd39,  8'd40,  8'd41,  8'd42,  8'd43,  8'd44,  8'd44,  8'd45,
        8'd46,  8'd47,  8'd48,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,
        8'd54,  8'd55,  8'd56,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,
        8'd62,  8'd63,  8'd64,  8'd66,  8'd67,  8'd68,  8'd69,  8'd70,
        8'd72,  8'd73,  8'd74,  8'd75,  8'd76,  8'd78,  8'd79,  8'd80,
        8'd82,  8'd83,  8'd84,  8'd86,  8'd87,  8'd88,  8'd90,  8'd91,
        8'd92,  8'd94,  8'd95,  8'd97,  8'd98,  8'd99,  8'd101, 8'd102,
        8'd104, 8'd105, 8'd107, 8'd108, 8'd110, 8'd111, 8'd113, 8'd114,
        8'd116, 8'd117, 8'd119, 8'd120, 8'd122, 8'd123, 8'd125, 8'd126,
        8'd128, 8'd129, 8'd130, 8'd132, 8'd133, 8'd135, 8'd136, 8'd138,
        8'd139, 8'd141, 8'd142, 8'd144, 8'd145, 8'd147, 8'd148, 8'd150,
        8'd151, 8'd153, 8'd154, 8'd156, 8'd157, 8'd158, 8'd160, 8'd161,
        8'd163, 8'd164, 8'd165, 8'd167, 8'd168, 8'd169, 8'd171, 8'd172,
        8'd173, 8'd175, 8'd176, 8'd177, 8'd179, 8'd180, 8'd181, 8'd182,
        8'd183, 8'd185, 8'd186, 8'd187, 8'd188, 8'd189, 8'd191, 8'd192,
        8'd193, 8'd194, 8'd195, 8'd196, 8'd197, 8'd198, 8'd199, 8'd200,
        8'd201, 8'd202, 8'd203, 8'd204, 8'd205, 8'd206, 8'd207, 8'd208,
        8'd209, 8'd210, 8'd211, 8'd211, 8'd212, 8'd213, 8'd214, 8'd215,
        8'd216, 8'd216, 8'd217, 8'd218, 8'd219, 8'd219, 8'd220, 8'd221,
        8'd221, 8'd222, 8'd223, 8'd223, 8'd224, 8'd225, 8'd225, 8'd226,
        8'd227, 8'd227, 8'd228, 8'd228, 8'd229, 8'd229, 8'd230, 8'd231,
        8'd231, 8'd232, 8'd232, 8'd233, 8'd233, 8'd234, 8'd234, 8'd234,
        8'd235, 8'd235, 8'd236, 8'd236, 8'd237, 8'd237, 8'd237, 8'd238,
        8'd238, 8'd239, 8'd239, 8'd239, 8'd240, 8'd240, 8'd240, 8'd241,
        8'd241, 8'd241, 8'd242, 8'd242, 8'd242, 8'd243, 8'd243, 8'd243
    };

    // Upper byte rounded by bit 7, held at 255 instead of wrapping.
    function automatic t_byte round_upper(input t_sum sum);
        t_byte v;
        v = sum[15:8];
        if (sum[7] && (v != 8'hFF)) begin
            v = v + 8'd1;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tiny_mlp_sigmoid_lut_inference_core.sv
// Two-layer quantized perceptron with sigmoid table, five-stage pipeline.
// Depends on tmlp_pkg (types, register indexes, table, rounding).
//
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+----------------------------------
//  input    | i_in_valid   | o_in_ready   | i_feature_0 .. i_feature_6
//  output   | o_out_valid  | i_out_ready  | o_class_score
//  config   | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One beat per cycle in and out while i_out_ready holds. A taken beat passes
// through the stages in order (products, half sums, hidden sum + table, output
// products, output sum + rounding) and is then offered on the output. The depth
// is set by the 8-term hidden adder split over two stages. Each stage holds its
// beat when the one below is full and stalled; bubbles collapse. Config writes
// are always taken. Reset is synchronous and clears the stage valids and the
// weights to zero.
`default_nettype none

module tiny_mlp_sigmoid_lut_inference_core #(
    parameter int unsigned INPUT_DIMENSION = 7
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,

    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire tmlp_pkg::t_byte  i_feature_0,
    input  wire tmlp_pkg::t_byte  i_feature_1,
    input  wire tmlp_pkg::t_byte  i_feature_2,
    input  wire tmlp_pkg::t_byte  i_feature_3,
    input  wire tmlp_pkg::t_byte  i_feature_4,
    input  wire tmlp_pkg::t_byte  i_feature_5,
    input  wire tmlp_pkg::t_byte  i_feature_6,

    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output tmlp_pkg::t_byte       o_class_score,

    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire tmlp_pkg::t_cfg_idx i_cfg_index,
    input  wire [63:0]            i_cfg_data
);

    import tmlp_pkg::*;

    localparam int unsigned NUM_STAGES = 5;

    // weights
    logic [63:0] r_cfg_a;
    logic [63:0] r_cfg_b;
    logic [23:0] r_cfg_o;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_adv;

    t_byte w_feat [NUM_FEATURES];

    t_sum  r_prod_a [INPUT_DIMENSION];
    t_sum  r_prod_b [INPUT_DIMENSION];
    t_sum  w_term_a [NUM_FEATURES+1];
    t_sum  w_term_b [NUM_FEATURES+1];
    t_sum  r_half_a [2];
    t_sum  r_half_b [2];
    t_sum  w_hsum_a;
    t_sum  w_hsum_b;
    t_byte r_hid_a;
    t_byte r_hid_b;
    t_sum  r_oprod_a;
    t_sum  r_oprod_b;
    t_sum  w_osum;
    t_byte r_score;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_a <= '0;
            r_cfg_b <= '0;
            r_cfg_o <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HIDDEN_A: r_cfg_a <= i_cfg_data;
                CFG_HIDDEN_B: r_cfg_b <= i_cfg_data;
                CFG_OUTPUT:   r_cfg_o <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    assign w_feat[0] = i_feature_0;
    assign w_feat[1] = i_feature_1;
    assign w_feat[2] = i_feature_2;
    assign w_feat[3] = i_feature_3;
    assign w_feat[4] = i_feature_4;
    assign w_feat[5] = i_feature_5;
    assign w_feat[6] = i_feature_6;

    // a stage loads when it is empty or its beat moves on
    always_comb begin
        w_adv[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_out_ready;
        for (int s = NUM_STAGES - 2; s >= 0; s--) begin
            w_adv[s] = !r_vld[s] || w_adv[s+1];
        end
    end

    assign o_in_ready  = w_adv[0];
    assign o_out_valid = r_vld[NUM_STAGES-1];
    assign o_class_score = r_score;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int s = 1; s < NUM_STAGES; s++) begin
                if (w_adv[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // stage 1: feature x weight products
    for (genvar k = 0; k < INPUT_DIMENSION; k++) begin : g_prod
        always_ff @(posedge i_clk) begin
            if (w_adv[0]) begin
                r_prod_a[k] <= t_sum'(w_feat[k]) * t_sum'(r_cfg_a[8*(k+1) +: 8]);
                r_prod_b[k] <= t_sum'(w_feat[k]) * t_sum'(r_cfg_b[8*(k+1) +: 8]);
            end
        end
    end

    assign w_term_a[0] = t_sum'(r_cfg_a[7:0]);
    assign w_term_b[0] = t_sum'(r_cfg_b[7:0]);

    // features past the configured dimension add nothing
    for (genvar k = 0; k < NUM_FEATURES; k++) begin : g_term
        if (k < INPUT_DIMENSION) begin : g_used
            assign w_term_a[k+1] = r_prod_a[k];
            assign w_term_b[k+1] = r_prod_b[k];
        end else begin : g_unused
            assign w_term_a[k+1] = '0;
            assign w_term_b[k+1] = '0;
        end
    end

    // stage 2: two four-term half sums per neuron, mod 2^16
    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_half_a[0] <= w_term_a[0] + w_term_a[1] + w_term_a[2] + w_term_a[3];
            r_half_a[1] <= w_term_a[4] + w_term_a[5] + w_term_a[6] + w_term_a[7];
            r_half_b[0] <= w_term_b[0] + w_term_b[1] + w_term_b[2] + w_term_b[3];
            r_half_b[1] <= w_term_b[4] + w_term_b[5] + w_term_b[6] + w_term_b[7];
        end
    end

    // stage 3: full sum, round, sigmoid lookup
    assign w_hsum_a = r_half_a[0] + r_half_a[1];
    assign w_hsum_b = r_half_b[0] + r_half_b[1];

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_hid_a <= SIGMOID_LUT[round_upper(w_hsum_a)];
            r_hid_b <= SIGMOID_LUT[round_upper(w_hsum_b)];
        end
    end

    // stage 4: hidden x output weight
    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r_oprod_a <= t_sum'(r_hid_a) * t_sum'(r_cfg_o[15:8]);
            r_oprod_b <= t_sum'(r_hid_b) * t_sum'(r_cfg_o[23:16]);
        end
    end

    // stage 5: bias + products, round with saturation
    assign w_osum = t_sum'(r_cfg_o[7:0]) + r_oprod_a + r_oprod_b;

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r_score <= round_upper(w_osum);
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/tmlp_checker.sv
// Port-level checks of the inference core, bound into the core module.
// Depends on tmlp_pkg and tiny_mlp_sigmoid_lut_inference_core_assert.svh.
`default_nettype none

`include "tiny_mlp_sigmoid_lut_inference_core_assert.svh"

module tmlp_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  o_in_ready,
    input wire                  o_out_valid,
    input wire                  i_out_ready,
    input wire tmlp_pkg::t_byte o_class_score
);

    import tmlp_pkg::*;

    // output beat held until taken
    `TMLP_ASSERT_NEXT(a_out_valid_hold, i_clk, !i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `TMLP_ASSERT_NEXT(a_out_data_hold, i_clk, !i_rst_n, o_out_valid && !i_out_ready, $stable(o_class_score))

    // an empty output stage lets ready ripple up to the input
    `TMLP_ASSERT_SAME(a_ready_when_drained, i_clk, !i_rst_n, !o_out_valid, o_in_ready)

    // reset empties the pipe
    `TMLP_ASSERT_NEXT(a_reset_clears, i_clk, 1'b0, !i_rst_n, !o_out_valid)

endmodule

bind tiny_mlp_sigmoid_lut_inference_core tmlp_checker u_tmlp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_class_score (o_class_score)
);

`default_nettype wire
